/* sv/bama_pkg.sv */
// Shared types and constants for the block average / moving average filter.
// No dependencies; compiled first.
package bama_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int AVG_W     = 8;
    localparam int SAMPLE_MAX = 255;

    localparam int BLOCK_SAMPLES_DEF = 32;
    localparam int WINDOW_DEPTH_DEF  = 16;

    // result words that may wait between the pipeline and the result port
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic                valid;
        logic [AVG_W-1:0]    value;
    } blk_t;

    typedef struct packed {
        logic [AVG_W-1:0]    average;
        logic                window_ready;
    } result_t;

endpackage

/* sv/bama_sample_if.sv */
// Sample channel: valid/ready handshake carrying one 8-bit converter sample.
// Depends on bama_pkg.
interface bama_sample_if;
    import bama_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* sv/bama_result_if.sv */
// Result channel: valid/ready handshake carrying the moving average and its flag.
// Depends on bama_pkg.
interface bama_result_if;
    import bama_pkg::*;

    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] average;
    logic             window_ready;

    modport source (output valid, output average, output window_ready, input ready);
    modport sink   (input valid, input average, input window_ready, output ready);
endinterface

/* sv/block_average_then_moving_average.sv */
// Block average followed by a moving average over the last WINDOW_DEPTH block
// averages. One sample is taken every cycle it is valid and not held off.
// Every BLOCK_SAMPLES samples the truncated block mean enters a ring of
// WINDOW_DEPTH entries held in a one-port-read, one-port-write synchronous
// memory, with a running total kept beside it; each block then yields one
// result word. While the ring fills the word is zero with window_ready low;
// from the block after the ring is full on, it is total / WINDOW_DEPTH with
// window_ready high. Up to four result words queue at the output; a sample
// that closes a block is held off only while four words wait unaccepted.
// The ring needs no clearing after reset: it is fully written before read.
// Depends on bama_pkg, bama_sample_if, bama_result_if and bama_block.
module block_average_then_moving_average #(
    parameter int BLOCK_SAMPLES = bama_pkg::BLOCK_SAMPLES_DEF,
    parameter int WINDOW_DEPTH  = bama_pkg::WINDOW_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bama_sample_if.sink   samples,
    bama_result_if.source results
);
    import bama_pkg::*;

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int TOT_W  = $clog2(SAMPLE_MAX * WINDOW_DEPTH + 1);
    localparam int KW     = TOT_W + $clog2(WINDOW_DEPTH);
    localparam int PROD_W = TOT_W + KW;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << KW) + longint'(WINDOW_DEPTH) - 1) / longint'(WINDOW_DEPTH);
    localparam logic [KW-1:0]     RECIP    = RECIP_FULL[KW-1:0];
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_DEPTH);
    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [OCNT_W-1:0] OCNT_MAX = OCNT_W'(OUT_DEPTH);

    logic   take;
    logic   at_last;
    blk_t   blk;

    // window ring
    logic [AVG_W-1:0]  ring_mem [WINDOW_DEPTH];
    logic [AVG_W-1:0]  oldest_reg;
    logic              w_valid_reg;
    logic [AVG_W-1:0]  w_blk_reg;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              full;
    logic              t_valid_reg;
    logic              t_full_reg;
    logic              a_valid_reg;
    logic              a_full_reg;
    logic [PROD_W-1:0] a_prod_reg;
    result_t           push_word;

    // output queue
    result_t           q_mem [OUT_DEPTH];
    logic [OPTR_W-1:0] q_wr_reg, q_rd_reg;
    logic [OCNT_W-1:0] q_cnt_reg, q_cnt_next;
    logic [OCNT_W-1:0] pend_reg, pend_next;
    logic              pop;

    bama_block #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES)
    ) u_block (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .sample  (samples.sample),
        .at_last (at_last),
        .blk     (blk)
    );

    // a block-closing sample needs a reserved slot in the output queue
    assign samples.ready = !at_last || (pend_reg != OCNT_MAX);
    assign take          = samples.valid && samples.ready;
    assign pop           = results.valid && results.ready;

    assign full = (fill_reg == FILL_MAX);

    always_comb
    begin
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        if (w_valid_reg)
        begin
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
            if (full)
                total_next = total_reg - TOT_W'(oldest_reg) + TOT_W'(w_blk_reg);
            else
            begin
                total_next = total_reg + TOT_W'(w_blk_reg);
                fill_next  = fill_reg + FILL_W'(1);
            end
        end
    end

    // block words never arrive back to back, so a read never meets
    // the write of the previous word at the same entry
    always_ff @(posedge clk)
    begin
        if (w_valid_reg)
            ring_mem[ptr_reg] <= w_blk_reg;
        if (blk.valid)
            oldest_reg <= ring_mem[ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (blk.valid)
            w_blk_reg <= blk.value;
        if (t_valid_reg)
            a_prod_reg <= PROD_W'(total_reg) * PROD_W'(RECIP);
        if (a_valid_reg)
            q_mem[q_wr_reg] <= push_word;
    end

    always_comb
    begin
        push_word.window_ready = a_full_reg;
        push_word.average      = a_full_reg ? a_prod_reg[KW +: AVG_W] : '0;
    end

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (a_valid_reg && !pop)
            q_cnt_next = q_cnt_reg + OCNT_W'(1);
        else if (!a_valid_reg && pop)
            q_cnt_next = q_cnt_reg - OCNT_W'(1);

        pend_next = pend_reg;
        if ((take && at_last) && !pop)
            pend_next = pend_reg + OCNT_W'(1);
        else if (!(take && at_last) && pop)
            pend_next = pend_reg - OCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg <= 1'b0;
            ptr_reg     <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            t_valid_reg <= 1'b0;
            t_full_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            a_full_reg  <= 1'b0;
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_cnt_reg   <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            w_valid_reg <= blk.valid;
            ptr_reg     <= ptr_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            t_valid_reg <= w_valid_reg;
            if (w_valid_reg)
                t_full_reg <= full;
            a_valid_reg <= t_valid_reg;
            if (t_valid_reg)
                a_full_reg <= t_full_reg;
            if (a_valid_reg)
                q_wr_reg <= q_wr_reg + OPTR_W'(1);
            if (pop)
                q_rd_reg <= q_rd_reg + OPTR_W'(1);
            q_cnt_reg   <= q_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    assign results.valid        = (q_cnt_reg != '0);
    assign results.average      = q_mem[q_rd_reg].average;
    assign results.window_ready = q_mem[q_rd_reg].window_ready;

endmodule

/* sv/bama_block.sv */
// Block accumulator: sums BLOCK_SAMPLES samples and forms their truncated mean.
// Depends on bama_pkg.
module bama_block #(
    parameter int BLOCK_SAMPLES = bama_pkg::BLOCK_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [bama_pkg::SAMPLE_W-1:0] sample,
    output logic                          at_last,
    output bama_pkg::blk_t                blk
);
    import bama_pkg::*;

    localparam int POS_W = $clog2(BLOCK_SAMPLES);
    localparam int ACC_W = $clog2(SAMPLE_MAX * BLOCK_SAMPLES + 1);
    localparam int KB    = ACC_W + $clog2(BLOCK_SAMPLES);
    localparam int PROD_W = ACC_W + KB;
    // ceil(2^KB / BLOCK_SAMPLES): exact floor quotient for every sum below 2^ACC_W
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << KB) + longint'(BLOCK_SAMPLES) - 1) / longint'(BLOCK_SAMPLES);
    localparam logic [KB-1:0] RECIP = RECIP_FULL[KB-1:0];
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SAMPLES - 1);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  sum_full;
    logic              sum_valid_reg;
    logic [ACC_W-1:0]  sum_reg;
    logic              prod_valid_reg;
    logic [PROD_W-1:0] prod_reg;

    assign at_last  = (pos_reg == POS_LAST);
    assign sum_full = acc_reg + ACC_W'(sample);

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        if (take)
        begin
            if (at_last)
            begin
                pos_next = '0;
                acc_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                acc_next = sum_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            acc_reg        <= '0;
            sum_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
            sum_valid_reg  <= take && at_last;
            prod_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && at_last)
            sum_reg <= sum_full;
        if (sum_valid_reg)
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
    end

    assign blk.valid = prod_valid_reg;
    assign blk.value = prod_reg[KB +: AVG_W];

endmodule
